@@ rtl/pgbh_pkg.sv @@
// Shared types, constants and helpers for the point grid binning histogram.
// Used by pgbh_ctrl, pgbh_dp and the top level; no dependencies.
package pgbh_pkg;

  localparam int GRID_SIZE_DEF = 4;
  localparam int COORD_W       = 32;
  localparam int COUNT_W       = 32;
  localparam int CELL_W        = 6;
  localparam int PATH_W        = 6;
  localparam int AXIS_MAX_W    = 4;   // axis index width at the largest grid
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_W        = 16;  // Q16.16 scale

  // octree child bits within one level
  localparam logic [2:0] OCT_X_BIT = 3'b100;
  localparam logic [2:0] OCT_Y_BIT = 3'b010;
  localparam logic [2:0] OCT_Z_BIT = 3'b001;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X   = 3'd0,
    CFG_MIN_Y   = 3'd1,
    CFG_MIN_Z   = 3'd2,
    CFG_SCALE_X = 3'd3,
    CFG_SCALE_Y = 3'd4,
    CFG_SCALE_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    REQ_POINT = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_e;

  typedef struct packed {
    logic                       req_type;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } in_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_index;
    logic [PATH_W-1:0]  octree_path;
    logic [COUNT_W-1:0] point_count;
    logic               last;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic load_pt;    // capture coordinate differences
    logic mul_en;     // scale multiply stage
    logic idx_en;     // clamp and form cell address
    logic rd_en;      // count memory read
    logic scan_sel;   // memory address from scan counter
    logic wr_en;      // count memory write
    logic wr_zero;    // write zero instead of incremented count
    logic scan_rst;
    logic scan_inc;
    logic pend_load;  // hold current scanned cell as pending result
    logic pend_clr;
    logic out_load;   // move pending result to output register
    logic out_last;
  } pgbh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_nonzero;
    logic scan_end;
    logic pend_valid;
    logic out_free;
  } pgbh_stat_t;

  // Octree path of a cell: one 3-bit code per level, top level first.
  // Works for grids that are not a power of two by halving the span.
  function automatic logic [PATH_W-1:0] octree_path(
    input logic [AXIS_MAX_W-1:0] ix,
    input logic [AXIS_MAX_W-1:0] iy,
    input logic [AXIS_MAX_W-1:0] iz,
    input int                    grid
  );
    logic [AXIS_MAX_W-1:0]   x;
    logic [AXIS_MAX_W-1:0]   y;
    logic [AXIS_MAX_W-1:0]   z;
    logic [3*AXIS_MAX_W-1:0] code;
    logic [2:0]              lvl;
    int                      span;
    int                      half;
    x    = ix;
    y    = iy;
    z    = iz;
    code = '0;
    span = grid;
    for (int k = 0; k < AXIS_MAX_W; k++) begin
      half = span >> 1;
      if (half != 0) begin
        lvl = '0;
        if (int'(x) >= half) begin
          lvl = lvl | OCT_X_BIT;
          x   = x - AXIS_MAX_W'(half);
        end
        if (int'(y) >= half) begin
          lvl = lvl | OCT_Y_BIT;
          y   = y - AXIS_MAX_W'(half);
        end
        if (int'(z) >= half) begin
          lvl = lvl | OCT_Z_BIT;
          z   = z - AXIS_MAX_W'(half);
        end
        code = {code[3*AXIS_MAX_W-4:0], lvl};
        span = half;
      end
    end
    return code[PATH_W-1:0];
  endfunction

endpackage

@@ rtl/pgbh_ctrl.sv @@
// Sequencer for the grid binning histogram: point update, flush scan, clear.
// Depends on pgbh_pkg; drives pgbh_dp through pgbh_cmd_t.
module pgbh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  pgbh_pkg::pgbh_stat_t stat,
  output pgbh_pkg::pgbh_cmd_t  cmd
);
  import pgbh_pkg::*;

  typedef enum logic [8:0] {
    ST_CLR   = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_PMUL  = 9'b000000100,
    ST_PIDX  = 9'b000001000,
    ST_PRD   = 9'b000010000,
    ST_PWR   = 9'b000100000,
    ST_SRD   = 9'b001000000,
    ST_SCHK  = 9'b010000000,
    ST_SLAST = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLR: begin
        cmd.scan_sel = 1'b1;
        cmd.wr_en    = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.scan_inc = 1'b1;
        if (stat.scan_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_FLUSH) begin
            cmd.scan_rst = 1'b1;
            state_next   = ST_SRD;
          end else begin
            cmd.load_pt = 1'b1;
            state_next  = ST_PMUL;
          end
        end
      end
      ST_PMUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_PIDX;
      end
      ST_PIDX: begin
        cmd.idx_en = 1'b1;
        state_next = ST_PRD;
      end
      ST_PRD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_PWR;
      end
      ST_PWR: begin
        cmd.wr_en  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SRD: begin
        cmd.rd_en    = 1'b1;
        cmd.scan_sel = 1'b1;
        state_next   = ST_SCHK;
      end
      ST_SCHK: begin
        // a new non-empty cell pushes the pending one out; wait for room
        if (!(stat.rd_nonzero && stat.pend_valid && !stat.out_free)) begin
          cmd.scan_sel = 1'b1;
          cmd.wr_en    = 1'b1;
          cmd.wr_zero  = 1'b1;
          if (stat.rd_nonzero) begin
            cmd.pend_load = 1'b1;
            cmd.out_load  = stat.pend_valid;
          end
          if (stat.scan_end) begin
            state_next = ST_SLAST;
          end else begin
            cmd.scan_inc = 1'b1;
            state_next   = ST_SRD;
          end
        end
      end
      ST_SLAST: begin
        if (!stat.pend_valid) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.pend_clr = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLR;
      end
    endcase
  end

endmodule

@@ rtl/pgbh_dp.sv @@
// Datapath: config registers, axis scaling, count memory, scan counters,
// pending result and output register. Depends on pgbh_pkg.
module pgbh_dp #(
  parameter int GRID_SIZE = pgbh_pkg::GRID_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pgbh_pkg::in_req_t             in_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pgbh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgbh_pkg::COORD_W-1:0]   cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pgbh_pkg::out_res_t            out_data,
  input  pgbh_pkg::pgbh_cmd_t           cmd,
  output pgbh_pkg::pgbh_stat_t          stat
);
  import pgbh_pkg::*;

  localparam int NUM_CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW        = $clog2(NUM_CELLS);
  localparam int CW        = $clog2(GRID_SIZE);
  localparam int QW        = 2 * COORD_W - FRAC_W;
  localparam logic [AW-1:0] GA       = AW'(GRID_SIZE);
  localparam logic [AW-1:0] GGA      = AW'(GRID_SIZE * GRID_SIZE);
  localparam logic [AW-1:0] LAST_A   = AW'(NUM_CELLS - 1);
  localparam logic [CW-1:0] AXIS_TOP = CW'(GRID_SIZE - 1);
  localparam logic [QW-1:0] Q_TOP    = QW'(GRID_SIZE - 1);

  // configuration
  logic signed [COORD_W-1:0] min_x, min_y, min_z;
  logic [COORD_W-1:0]        scale_x, scale_y, scale_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x   <= '0;
      min_y   <= '0;
      min_z   <= '0;
      scale_x <= COORD_W'(1 << FRAC_W);
      scale_y <= COORD_W'(1 << FRAC_W);
      scale_z <= COORD_W'(1 << FRAC_W);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_X:   min_x   <= cfg_data;
        CFG_MIN_Y:   min_y   <= cfg_data;
        CFG_MIN_Z:   min_z   <= cfg_data;
        CFG_SCALE_X: scale_x <= cfg_data;
        CFG_SCALE_Y: scale_y <= cfg_data;
        CFG_SCALE_Z: scale_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: coordinate minus origin; a positive difference fits 32 bits
  logic [COORD_W:0]   dx, dy, dz;
  logic               pos_x, pos_y, pos_z;
  logic [COORD_W-1:0] mag_x, mag_y, mag_z;

  assign dx = {in_data.coord_x[COORD_W-1], in_data.coord_x} - {min_x[COORD_W-1], min_x};
  assign dy = {in_data.coord_y[COORD_W-1], in_data.coord_y} - {min_y[COORD_W-1], min_y};
  assign dz = {in_data.coord_z[COORD_W-1], in_data.coord_z} - {min_z[COORD_W-1], min_z};

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      pos_x <= !dx[COORD_W] && (|dx[COORD_W-1:0]);
      pos_y <= !dy[COORD_W] && (|dy[COORD_W-1:0]);
      pos_z <= !dz[COORD_W] && (|dz[COORD_W-1:0]);
      mag_x <= dx[COORD_W-1:0];
      mag_y <= dy[COORD_W-1:0];
      mag_z <= dz[COORD_W-1:0];
    end
  end

  // stage 2: scale multiply
  logic [2*COORD_W-1:0] prod_x, prod_y, prod_z;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_x <= (2*COORD_W)'(mag_x) * (2*COORD_W)'(scale_x);
      prod_y <= (2*COORD_W)'(mag_y) * (2*COORD_W)'(scale_y);
      prod_z <= (2*COORD_W)'(mag_z) * (2*COORD_W)'(scale_z);
    end
  end

  // stage 3: floor, clamp, linear cell address
  logic [QW-1:0] q_x, q_y, q_z;
  logic [CW-1:0] ix, iy, iz;
  logic [AW-1:0] pt_addr;

  assign q_x = prod_x[2*COORD_W-1:FRAC_W];
  assign q_y = prod_y[2*COORD_W-1:FRAC_W];
  assign q_z = prod_z[2*COORD_W-1:FRAC_W];

  always_comb begin
    ix = !pos_x ? '0 : (q_x > Q_TOP) ? AXIS_TOP : q_x[CW-1:0];
    iy = !pos_y ? '0 : (q_y > Q_TOP) ? AXIS_TOP : q_y[CW-1:0];
    iz = !pos_z ? '0 : (q_z > Q_TOP) ? AXIS_TOP : q_z[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_en) begin
      pt_addr <= AW'(ix) + AW'(GA * AW'(iy)) + AW'(GGA * AW'(iz));
    end
  end

  // scan counters, kept per axis to avoid dividing the address
  logic [AW-1:0] scan_addr;
  logic [CW-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_rst) begin
      scan_addr <= '0;
      sx        <= '0;
      sy        <= '0;
      sz        <= '0;
    end else if (cmd.scan_inc) begin
      scan_addr <= (scan_addr == LAST_A) ? '0 : scan_addr + AW'(1);
      if (sx == AXIS_TOP) begin
        sx <= '0;
        if (sy == AXIS_TOP) begin
          sy <= '0;
          sz <= (sz == AXIS_TOP) ? '0 : sz + CW'(1);
        end else begin
          sy <= sy + CW'(1);
        end
      end else begin
        sx <= sx + CW'(1);
      end
    end
  end

  // count memory, single port
  logic [COUNT_W-1:0] mem [NUM_CELLS];
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] wr_data;
  logic [AW-1:0]      mem_addr;

  assign mem_addr = cmd.scan_sel ? scan_addr : pt_addr;
  assign wr_data  = cmd.wr_zero ? '0 :
                    (&rd_data) ? rd_data : rd_data + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[mem_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[mem_addr];
    end
  end

  // pending result: held until the next non-empty cell or end of scan
  logic               pend_valid;
  logic [CELL_W-1:0]  pend_index;
  logic [PATH_W-1:0]  pend_path;
  logic [COUNT_W-1:0] pend_count;

  always_ff @(posedge clk) begin
    if (rst || cmd.pend_clr) begin
      pend_valid <= 1'b0;
    end else if (cmd.pend_load) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_index <= CELL_W'(scan_addr);
      pend_path  <= octree_path(AXIS_MAX_W'(sx), AXIS_MAX_W'(sy), AXIS_MAX_W'(sz),
                                GRID_SIZE);
      pend_count <= rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.cell_index  <= pend_index;
      out_data.octree_path <= pend_path;
      out_data.point_count <= pend_count;
      out_data.last        <= cmd.out_last;
    end
  end

  assign stat.rd_nonzero = |rd_data;
  assign stat.scan_end   = (scan_addr == LAST_A);
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = !out_valid || out_ready;

  a_out_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_pend_kept: assert property (@(posedge clk) disable iff (rst)
    (cmd.pend_load && pend_valid) |-> cmd.out_load)
    else $error("pending result overwritten");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> (!pend_valid && out_valid && out_data.last))
    else $error("final result not staged");

  a_scan_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.scan_sel) |-> cmd.wr_zero)
    else $error("scan write with nonzero data");

endmodule

@@ rtl/point_grid_binning_histogram.sv @@
// Point grid binning histogram, top level: pgbh_ctrl sequencer and pgbh_dp datapath.
// Depends on pgbh_pkg, pgbh_ctrl, pgbh_dp.
//
// A point request goes from acceptance to the count update through the steps
// (difference, 32x32 scale multiply, clamp and address, memory read, write back),
// ending in a read-modify-write on the single-port count memory; the next request
// is taken in the cycle after the write. A flush request reads and clears every
// one of the GRID_SIZE^3 cells in turn, each read and then cleared, and waits while
// the output is stalled; non-empty cells come out in increasing index order,
// the final one marked last. After reset a clearing pass zeroes every count
// before the first request is accepted; configuration writes are accepted in
// every cycle and must only be made while the block is idle.
module point_grid_binning_histogram #(
  parameter int GRID_SIZE = pgbh_pkg::GRID_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pgbh_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pgbh_pkg::out_res_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pgbh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgbh_pkg::COORD_W-1:0]   cfg_data
);
  import pgbh_pkg::*;

  pgbh_cmd_t  cmd;
  pgbh_stat_t stat;

  pgbh_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_data.req_type),
    .stat        (stat),
    .cmd         (cmd)
  );

  pgbh_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
